>>> rtl/kgt_pkg.sv
// Shared constants, action codes and helpers for the keyed goal table.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package kgt_pkg;

  // Table geometry
  localparam int CAPACITY = 48;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_DEPTH = 3 * CAPACITY;
  localparam int VA_W     = $clog2(VAL_DEPTH);

  // Field widths of the words on the channels
  localparam int ACT_W  = 3;
  localparam int KEY_W  = 16;
  localparam int FLAG_W = 8;
  localparam int VAL_W  = 32;
  localparam int START_W = 6;
  localparam int RIDX_W = 7;
  localparam int GCNT_W = 6;

  // Action codes
  localparam logic [ACT_W-1:0] ACT_CLEAR  = 3'd0;
  localparam logic [ACT_W-1:0] ACT_INSERT = 3'd1;
  localparam logic [ACT_W-1:0] ACT_SETFLG = 3'd2;
  localparam logic [ACT_W-1:0] ACT_SEARCH = 3'd3;
  localparam logic [ACT_W-1:0] ACT_NEXTUP = 3'd4;
  localparam logic [ACT_W-1:0] ACT_READ   = 3'd5;

  // Result index meaning "nothing found"
  localparam logic [RIDX_W-1:0] IDX_NONE = {RIDX_W{1'b1}};

  // Word address of value a of an entry (b and c follow it)
  function automatic logic [VA_W-1:0] val_base(input logic [IDX_W-1:0] idx);
    logic [VA_W-1:0] wide;
    wide = VA_W'(idx);
    return (wide << 1) + wide;
  endfunction

endpackage

>>> rtl/kgt_cmd_if.sv
// Command channel of the keyed goal table: valid/ready plus one command word.
// Depends on kgt_pkg for the field widths.
`timescale 1ns / 1ps

interface kgt_cmd_if
  import kgt_pkg::*;
;
  logic                       valid;
  logic                       ready;
  logic        [ACT_W-1:0]    action;
  logic        [KEY_W-1:0]    key;
  logic signed [VAL_W-1:0]    value_a;
  logic signed [VAL_W-1:0]    value_b;
  logic signed [VAL_W-1:0]    value_c;
  logic        [FLAG_W-1:0]   flag_bits;
  logic        [START_W-1:0]  start_index;

  modport source (output valid, action, key, value_a, value_b, value_c, flag_bits,
                  start_index, input ready);
  modport sink   (input valid, action, key, value_a, value_b, value_c, flag_bits,
                  start_index, output ready);
endinterface

>>> rtl/kgt_rsp_if.sv
// Response channel of the keyed goal table: valid/ready plus one result word.
// Depends on kgt_pkg for the field widths.
`timescale 1ns / 1ps

interface kgt_rsp_if
  import kgt_pkg::*;
;
  logic                       valid;
  logic                       ready;
  logic signed [RIDX_W-1:0]   result_index;
  logic                       hit;
  logic        [GCNT_W-1:0]   goal_count;
  logic        [KEY_W-1:0]    entry_key;
  logic        [FLAG_W-1:0]   entry_flags;
  logic signed [VAL_W-1:0]    entry_a;
  logic signed [VAL_W-1:0]    entry_b;
  logic signed [VAL_W-1:0]    entry_c;

  modport source (output valid, result_index, hit, goal_count, entry_key, entry_flags,
                  entry_a, entry_b, entry_c, input ready);
  modport sink   (input valid, result_index, hit, goal_count, entry_key, entry_flags,
                  entry_a, entry_b, entry_c, output ready);
endinterface

>>> rtl/keyed_goal_table_max_merge_top.sv
// Keyed goal table with max-merge on insert: sequencer, entry memories, output register.
// Depends on kgt_pkg, kgt_cmd_if and kgt_rsp_if.
`timescale 1ns / 1ps

// Usage
//   cmd : command words (clear, insert, set flags, search, next unprotected, read).
//   rsp : one result word for every command word, in order.
//   A word moves when valid and ready are both high at a rising edge of clk.
//   cmd.ready is high only while the sequencer is idle: one command at a time.
// Work per command (accept to rsp.valid, receiver ready)
//   clear, undefined action, read out of range : straight to the done state
//   search / set flags / next unprotected      : key scan until a hit or the count
//   insert, new entry                          : key scan, then append of three value words
//   insert, existing key                       : key scan, then three read/compare/write passes
//   read                                       : three read/capture passes
//   The key scan runs one entry a cycle through the key and flag memories; the single
//   signed comparator works on one value word at a time.
// Reset (rst, synchronous) empties the table and the output register. The entry
//   memories are not cleared; only entries below the count are ever read.
// A stalled receiver leaves the finished word in the output register; the block
//   returns to idle and takes the next command, then waits before its result.
module keyed_goal_table_max_merge_top
  import kgt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  kgt_cmd_if.sink    cmd,
  kgt_rsp_if.source  rsp
);

  // Sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_MRD  = 3'd2;
  localparam logic [2:0] S_MCMP = 3'd3;
  localparam logic [2:0] S_APP  = 3'd4;
  localparam logic [2:0] S_RD   = 3'd5;
  localparam logic [2:0] S_RCAP = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  logic [2:0] state;

  // Entry memories
  logic [KEY_W-1:0]  key_mem  [CAPACITY];
  logic [FLAG_W-1:0] flag_mem [CAPACITY];
  logic [VAL_W-1:0]  val_mem  [VAL_DEPTH];

  logic [KEY_W-1:0]  key_q;
  logic [FLAG_W-1:0] flag_q;
  logic signed [VAL_W-1:0] val_q;

  // Latched command word
  logic [ACT_W-1:0]        cmd_act;
  logic [KEY_W-1:0]        cmd_key;
  logic signed [VAL_W-1:0] cmd_va;
  logic signed [VAL_W-1:0] cmd_vb;
  logic signed [VAL_W-1:0] cmd_vc;
  logic [FLAG_W-1:0]       cmd_bits;
  logic [START_W-1:0]      cmd_start;

  // Table count and scan pointers
  logic [CNT_W-1:0] total;
  logic [CNT_W-1:0] scan_idx;
  logic             chk_vld;
  logic [IDX_W-1:0] chk_idx;
  logic [VA_W-1:0]  val_addr;
  logic [1:0]       vk;

  // Result being built
  logic [RIDX_W-1:0]       res_idx;
  logic                    res_hit;
  logic [KEY_W-1:0]        res_key;
  logic [FLAG_W-1:0]       res_flags;
  logic signed [VAL_W-1:0] res_a;
  logic signed [VAL_W-1:0] res_b;
  logic signed [VAL_W-1:0] res_c;

  // Output register
  logic                    out_vld;
  logic [RIDX_W-1:0]       out_idx;
  logic                    out_hit;
  logic [GCNT_W-1:0]       out_cnt;
  logic [KEY_W-1:0]        out_key;
  logic [FLAG_W-1:0]       out_flags;
  logic signed [VAL_W-1:0] out_a;
  logic signed [VAL_W-1:0] out_b;
  logic signed [VAL_W-1:0] out_c;

  logic                    accept;
  logic [IDX_W-1:0]        key_rd_addr;
  logic                    chk_match;
  logic                    can_issue;
  logic                    hit_now;
  logic                    miss_now;
  logic                    room;
  logic                    app_go;
  logic signed [VAL_W-1:0] v_sel;
  logic                    v_gt;
  logic                    load_out;

  assign cmd.ready = (state == S_IDLE);
  assign accept    = cmd.valid && cmd.ready;

  // Scan step: compare the word read last cycle, decide whether to read on
  assign key_rd_addr = (state == S_RD) ? IDX_W'(cmd_start) : scan_idx[IDX_W-1:0];
  assign chk_match   = (cmd_act == ACT_NEXTUP) ? !flag_q[0] : (key_q == cmd_key);
  assign can_issue   = (scan_idx < total);
  assign hit_now     = (state == S_SCAN) && chk_vld && chk_match;
  assign miss_now    = (state == S_SCAN) && !hit_now && !can_issue;
  assign room        = (total < CNT_W'(CAPACITY));
  assign app_go      = miss_now && (cmd_act == ACT_INSERT) && room;

  // Shared signed comparator on one value word at a time
  always_comb begin
    case (vk)
      2'd0:    v_sel = cmd_va;
      2'd1:    v_sel = cmd_vb;
      default: v_sel = cmd_vc;
    endcase
  end
  assign v_gt = (v_sel > val_q);

  assign load_out = (state == S_DONE) && (!out_vld || rsp.ready);

  // Memory read ports, registered
  always_ff @(posedge clk) begin
    key_q  <= key_mem[key_rd_addr];
    flag_q <= flag_mem[key_rd_addr];
    val_q  <= val_mem[val_addr];
  end

  // Key memory: written only when an entry is appended
  always_ff @(posedge clk) begin
    if (app_go) begin
      key_mem[total[IDX_W-1:0]] <= cmd_key;
    end
  end

  // Flag memory: cleared on append, ORed by set flags
  always_ff @(posedge clk) begin
    if (app_go) begin
      flag_mem[total[IDX_W-1:0]] <= '0;
    end else if (hit_now && cmd_act == ACT_SETFLG) begin
      flag_mem[chk_idx] <= flag_q | cmd_bits;
    end
  end

  // Value memory: written on append and when the new value is larger
  always_ff @(posedge clk) begin
    if (state == S_APP || (state == S_MCMP && v_gt)) begin
      val_mem[val_addr] <= v_sel;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      total   <= '0;
      chk_vld <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            cmd_act   <= cmd.action;
            cmd_key   <= cmd.key;
            cmd_va    <= cmd.value_a;
            cmd_vb    <= cmd.value_b;
            cmd_vc    <= cmd.value_c;
            cmd_bits  <= cmd.flag_bits;
            cmd_start <= cmd.start_index;
            res_idx   <= IDX_NONE;
            res_hit   <= 1'b0;
            res_key   <= '0;
            res_flags <= '0;
            res_a     <= '0;
            res_b     <= '0;
            res_c     <= '0;
            chk_vld   <= 1'b0;
            vk        <= '0;
            val_addr  <= val_base(IDX_W'(cmd.start_index));
            case (cmd.action)
              ACT_CLEAR: begin
                total <= '0;
                state <= S_DONE;
              end
              ACT_INSERT, ACT_SETFLG, ACT_SEARCH: begin
                scan_idx <= '0;
                state    <= S_SCAN;
              end
              ACT_NEXTUP: begin
                scan_idx <= CNT_W'(cmd.start_index);
                state    <= S_SCAN;
              end
              ACT_READ: begin
                state <= (CNT_W'(cmd.start_index) < total) ? S_RD : S_DONE;
              end
              default: state <= S_DONE;
            endcase
          end
        end

        S_SCAN: begin
          if (hit_now) begin
            chk_vld <= 1'b0;
            res_idx <= RIDX_W'(chk_idx);
            res_hit <= (cmd_act != ACT_NEXTUP);
            if (cmd_act == ACT_INSERT) begin
              val_addr <= val_base(chk_idx);
              vk       <= '0;
              state    <= S_MRD;
            end else begin
              state <= S_DONE;
            end
          end else if (can_issue) begin
            chk_vld  <= 1'b1;
            chk_idx  <= scan_idx[IDX_W-1:0];
            scan_idx <= scan_idx + 1'b1;
          end else begin
            chk_vld <= 1'b0;
            if (app_go) begin
              res_idx  <= RIDX_W'(total);
              total    <= total + 1'b1;
              val_addr <= val_base(total[IDX_W-1:0]);
              vk       <= '0;
              state    <= S_APP;
            end else begin
              state <= S_DONE;
            end
          end
        end

        // Merge: read one value word, then compare and write back
        S_MRD: state <= S_MCMP;
        S_MCMP: begin
          vk       <= vk + 1'b1;
          val_addr <= val_addr + 1'b1;
          state    <= (vk == 2'd2) ? S_DONE : S_MRD;
        end

        // Append: one value word a cycle
        S_APP: begin
          vk       <= vk + 1'b1;
          val_addr <= val_addr + 1'b1;
          if (vk == 2'd2) begin
            state <= S_DONE;
          end
        end

        // Read entry: key and flags with the first word, then b and c
        S_RD: state <= S_RCAP;
        S_RCAP: begin
          case (vk)
            2'd0: begin
              res_idx   <= RIDX_W'(cmd_start);
              res_key   <= key_q;
              res_flags <= flag_q;
              res_a     <= val_q;
            end
            2'd1:    res_b <= val_q;
            default: res_c <= val_q;
          endcase
          vk       <= vk + 1'b1;
          val_addr <= val_addr + 1'b1;
          state    <= (vk == 2'd2) ? S_DONE : S_RD;
        end

        S_DONE: begin
          if (load_out) begin
            state <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (load_out) begin
      out_vld <= 1'b1;
    end else if (rsp.ready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_idx   <= res_idx;
      out_hit   <= res_hit;
      out_cnt   <= GCNT_W'(total);
      out_key   <= res_key;
      out_flags <= res_flags;
      out_a     <= res_a;
      out_b     <= res_b;
      out_c     <= res_c;
    end
  end

  assign rsp.valid        = out_vld;
  assign rsp.result_index = out_idx;
  assign rsp.hit          = out_hit;
  assign rsp.goal_count   = out_cnt;
  assign rsp.entry_key    = out_key;
  assign rsp.entry_flags  = out_flags;
  assign rsp.entry_a      = out_a;
  assign rsp.entry_b      = out_b;
  assign rsp.entry_c      = out_c;

  // Checks
  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    total <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    accept |=> !cmd.ready)
    else $error("second command taken while busy");

  a_hit_has_index: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !(rsp.hit && rsp.result_index == IDX_NONE))
    else $error("hit reported without an index");

  a_append_counts: assert property (@(posedge clk) disable iff (rst)
    app_go |=> total == $past(total) + 1'b1)
    else $error("append did not advance the count");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && chk_vld) |-> (CNT_W'(chk_idx) < total))
    else $error("scan compared an entry beyond the count");

endmodule

>>> test/tb_keyed_goal_table_max_merge_top.sv
// Testbench for keyed_goal_table_max_merge_top: directed and random command words,
// checked against an in-bench table model. Depends on kgt_pkg, kgt_cmd_if, kgt_rsp_if.
`timescale 1ns / 1ps

module tb_keyed_goal_table_max_merge_top
  import kgt_pkg::*;
;

  // Run limits and stimulus sizes
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int END_WAIT     = 64;
  localparam int PHASE_WORDS  = 480;
  localparam int POOL_SIZE    = 64;
  localparam int HOLD_CYCLES  = 300;
  localparam int REPORT_LIMIT = 100;

  // Action codes the block leaves undefined
  localparam logic [ACT_W-1:0] ACT_UNUSED_LO = 3'd6;
  localparam logic [ACT_W-1:0] ACT_UNUSED_HI = 3'd7;

  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

  typedef struct packed {
    logic        [ACT_W-1:0]   action;
    logic        [KEY_W-1:0]   key;
    logic signed [VAL_W-1:0]   value_a;
    logic signed [VAL_W-1:0]   value_b;
    logic signed [VAL_W-1:0]   value_c;
    logic        [FLAG_W-1:0]  flag_bits;
    logic        [START_W-1:0] start_index;
  } goal_cmd_t;

  typedef struct packed {
    logic signed [RIDX_W-1:0] result_index;
    logic                     hit;
    logic        [GCNT_W-1:0] goal_count;
    logic        [KEY_W-1:0]  entry_key;
    logic        [FLAG_W-1:0] entry_flags;
    logic signed [VAL_W-1:0]  entry_a;
    logic signed [VAL_W-1:0]  entry_b;
    logic signed [VAL_W-1:0]  entry_c;
  } goal_rsp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  kgt_cmd_if cmd_ch ();
  kgt_rsp_if rsp_ch ();

  keyed_goal_table_max_merge_top u_dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .rsp (rsp_ch)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Table model state
  int                       tbl_count;
  logic        [KEY_W-1:0]  tbl_key   [CAPACITY];
  logic        [FLAG_W-1:0] tbl_flags [CAPACITY];
  logic signed [VAL_W-1:0]  tbl_val   [VAL_DEPTH];

  goal_rsp_t          pending_results [$];
  logic [KEY_W-1:0]   key_pool [POOL_SIZE];
  int                 mismatch_count;
  int                 words_checked;
  int                 cycle_count;
  int                 sender_idle_pct;
  int                 sink_stall_pct;
  int                 hold_off_left;

  // Mismatch reporting: one line each, counted, printing capped
  task automatic report_mismatch(input string msg);
    if (mismatch_count < REPORT_LIMIT)
      $display("ERROR @%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [VAL_W-1:0] got,
                             input logic [VAL_W-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("word %0d %s: got %h, want %h", words_checked, name,
                                got, want));
  endtask

  // First matching entry, or -1
  function automatic int find_goal(input logic [KEY_W-1:0] key);
    for (int i = 0; i < tbl_count; i++)
      if (tbl_key[i] == key) return i;
    return -1;
  endfunction

  // Applies one command word to the table model and returns the result word
  function automatic goal_rsp_t predict_goal_table(input goal_cmd_t c);
    goal_rsp_t               r;
    logic signed [VAL_W-1:0] v [3];
    int                      pos;
    int                      found;
    r = '0;
    r.result_index = IDX_NONE;
    v[0] = c.value_a;
    v[1] = c.value_b;
    v[2] = c.value_c;
    pos = find_goal(c.key);
    found = -1;
    case (c.action)
      ACT_CLEAR: tbl_count = 0;
      ACT_INSERT: begin
        if (pos >= 0) begin
          // signed max-merge into the existing entry
          for (int k = 0; k < 3; k++)
            if (v[k] > tbl_val[3 * pos + k]) tbl_val[3 * pos + k] = v[k];
          r.result_index = RIDX_W'(pos);
          r.hit = 1'b1;
        end else if (tbl_count < CAPACITY) begin
          tbl_key[tbl_count] = c.key;
          tbl_flags[tbl_count] = '0;
          for (int k = 0; k < 3; k++) tbl_val[3 * tbl_count + k] = v[k];
          r.result_index = RIDX_W'(tbl_count);
          tbl_count++;
        end
      end
      ACT_SETFLG, ACT_SEARCH: begin
        if (pos >= 0) begin
          if (c.action == ACT_SETFLG) tbl_flags[pos] = tbl_flags[pos] | c.flag_bits;
          r.result_index = RIDX_W'(pos);
          r.hit = 1'b1;
        end
      end
      ACT_NEXTUP: begin
        for (int k = int'(c.start_index); k < tbl_count; k++)
          if (found < 0 && !tbl_flags[k][0]) found = k;
        if (found >= 0) r.result_index = RIDX_W'(found);
      end
      ACT_READ: begin
        if (int'(c.start_index) < tbl_count) begin
          r.result_index = RIDX_W'(c.start_index);
          r.entry_key    = tbl_key[c.start_index];
          r.entry_flags  = tbl_flags[c.start_index];
          r.entry_a      = tbl_val[3 * c.start_index];
          r.entry_b      = tbl_val[3 * c.start_index + 1];
          r.entry_c      = tbl_val[3 * c.start_index + 2];
        end
      end
      default: ;
    endcase
    r.goal_count = GCNT_W'(tbl_count);
    return r;
  endfunction

  function automatic goal_cmd_t make_cmd(input logic [ACT_W-1:0] action,
                                         input logic [KEY_W-1:0] key,
                                         input logic signed [VAL_W-1:0] a,
                                         input logic signed [VAL_W-1:0] b,
                                         input logic signed [VAL_W-1:0] c,
                                         input logic [FLAG_W-1:0] flags,
                                         input logic [START_W-1:0] start);
    goal_cmd_t w;
    w.action      = action;
    w.key         = key;
    w.value_a     = a;
    w.value_b     = b;
    w.value_c     = c;
    w.flag_bits   = flags;
    w.start_index = start;
    return w;
  endfunction

  // Values: extremes, small numbers near zero so merges go both ways, or anything
  function automatic logic signed [VAL_W-1:0] rand_value();
    case ($urandom_range(9))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      2:       return '0;
      3:       return -1;
      4, 5:    return VAL_W'($urandom_range(200)) - 100;
      default: return VAL_W'($urandom);
    endcase
  endfunction

  // Mostly pool keys so that matches happen and the table fills; some wild misses
  function automatic goal_cmd_t random_goal_cmd();
    goal_cmd_t   w;
    int unsigned pick;
    w.key = ($urandom_range(9) == 0) ? KEY_W'($urandom)
                                     : key_pool[$urandom_range(POOL_SIZE - 1)];
    w.value_a = rand_value();
    w.value_b = rand_value();
    w.value_c = rand_value();
    w.flag_bits = ($urandom_range(1) == 0) ? FLAG_W'($urandom)
                                           : FLAG_W'(1) << $urandom_range(FLAG_W - 1);
    w.start_index = ($urandom_range(3) == 0) ? START_W'($urandom)
                                             : START_W'($urandom_range(CAPACITY - 1));
    pick = $urandom_range(99);
    if (pick < 2)       w.action = ACT_CLEAR;
    else if (pick < 37) w.action = ACT_INSERT;
    else if (pick < 52) w.action = ACT_SETFLG;
    else if (pick < 67) w.action = ACT_SEARCH;
    else if (pick < 80) w.action = ACT_NEXTUP;
    else if (pick < 98) w.action = ACT_READ;
    else                w.action = pick[0] ? ACT_UNUSED_LO : ACT_UNUSED_HI;
    return w;
  endfunction

  // Offers one word from a falling edge; returns at the falling edge after acceptance
  // with valid still high, so the next word can follow without a gap.
  task automatic offer_command(input goal_cmd_t w);
    while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      cmd_ch.valid = 1'b0;
      @(negedge clk);
    end
    cmd_ch.action      = w.action;
    cmd_ch.key         = w.key;
    cmd_ch.value_a     = w.value_a;
    cmd_ch.value_b     = w.value_b;
    cmd_ch.value_c     = w.value_c;
    cmd_ch.flag_bits   = w.flag_bits;
    cmd_ch.start_index = w.start_index;
    cmd_ch.valid       = 1'b1;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    pending_results.push_back(predict_goal_table(w));
    @(negedge clk);
  endtask

  // Sender pauses until every expected result word has come back
  task automatic wait_all_results();
    cmd_ch.valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic test_empty_table();
    sender_idle_pct = 0;
    sink_stall_pct  = 0;
    offer_command(make_cmd(ACT_CLEAR, '0, '0, '0, '0, '0, '0));
    offer_command(make_cmd(ACT_READ, '0, '0, '0, '0, '0, '0));
    offer_command(make_cmd(ACT_NEXTUP, '0, '0, '0, '0, '0, '0));
    offer_command(make_cmd(ACT_SEARCH, '0, '0, '0, '0, '0, '0));
    offer_command(make_cmd(ACT_SETFLG, 16'hFFFF, '0, '0, '0, 8'hFF, '0));
    wait_all_results();
  endtask

  // New entries, then merges that raise some values and leave others
  task automatic test_insert_merge();
    offer_command(make_cmd(ACT_INSERT, 16'h0000, VAL_MIN, VAL_MAX, '0, '0, '0));
    offer_command(make_cmd(ACT_INSERT, 16'h0000, VAL_MAX, VAL_MIN, -1, '0, '0));
    offer_command(make_cmd(ACT_INSERT, 16'hFFFF, -1, '0, 1, '0, '0));
    offer_command(make_cmd(ACT_INSERT, 16'hFFFF, -2, 1, VAL_MIN, '0, '0));
    offer_command(make_cmd(ACT_READ, '0, '0, '0, '0, '0, 6'd0));
    offer_command(make_cmd(ACT_READ, '0, '0, '0, '0, '0, 6'd1));
    wait_all_results();
  endtask

  // Protect entry 0, mark entry 1 without protecting it, then scan
  task automatic test_flags_and_scan();
    offer_command(make_cmd(ACT_SETFLG, 16'h0000, '0, '0, '0, 8'hFF, '0));
    offer_command(make_cmd(ACT_SETFLG, 16'hFFFF, '0, '0, '0, 8'h02, '0));
    offer_command(make_cmd(ACT_SEARCH, 16'hFFFF, '0, '0, '0, '0, '0));
    offer_command(make_cmd(ACT_NEXTUP, '0, '0, '0, '0, '0, 6'd0));
    offer_command(make_cmd(ACT_NEXTUP, '0, '0, '0, '0, '0, 6'd1));
    offer_command(make_cmd(ACT_NEXTUP, '0, '0, '0, '0, '0, 6'd2));
    offer_command(make_cmd(ACT_NEXTUP, '0, '0, '0, '0, '0, 6'd63));
    offer_command(make_cmd(ACT_READ, '0, '0, '0, '0, '0, 6'd63));
    offer_command(make_cmd(ACT_READ, '0, '0, '0, '0, '0, 6'd2));
    wait_all_results();
  endtask

  task automatic test_undefined_actions();
    offer_command(make_cmd(ACT_UNUSED_LO, 16'h0000, VAL_MAX, VAL_MAX, VAL_MAX, 8'hFF,
                           6'd0));
    offer_command(make_cmd(ACT_UNUSED_HI, 16'hFFFF, VAL_MIN, VAL_MIN, VAL_MIN, 8'hFF,
                           6'd1));
    wait_all_results();
  endtask

  // Fill all entries, then an insert of a new key is dropped; merges still work
  task automatic test_table_full();
    logic [KEY_W-1:0] base;
    base = KEY_W'($urandom);
    sender_idle_pct = 30;
    sink_stall_pct  = 30;
    offer_command(make_cmd(ACT_CLEAR, '0, '0, '0, '0, '0, '0));
    for (int i = 0; i < CAPACITY; i++)
      offer_command(make_cmd(ACT_INSERT, base + KEY_W'(i), rand_value(), rand_value(),
                             rand_value(), '0, '0));
    offer_command(make_cmd(ACT_INSERT, base + KEY_W'(CAPACITY), rand_value(),
                           rand_value(), rand_value(), '0, '0));
    offer_command(make_cmd(ACT_INSERT, base + KEY_W'(CAPACITY - 1), VAL_MAX, rand_value(),
                           rand_value(), '0, '0));
    offer_command(make_cmd(ACT_SEARCH, base + KEY_W'(CAPACITY - 1), '0, '0, '0, '0, '0));
    offer_command(make_cmd(ACT_NEXTUP, '0, '0, '0, '0, '0, START_W'(CAPACITY - 1)));
    offer_command(make_cmd(ACT_READ, '0, '0, '0, '0, '0, START_W'(CAPACITY - 1)));
    offer_command(make_cmd(ACT_READ, '0, '0, '0, '0, '0, START_W'(CAPACITY)));
    wait_all_results();
  endtask

  // Receiver holds off while the sender keeps offering, so the block stalls its input
  task automatic test_backpressure();
    sender_idle_pct = 0;
    sink_stall_pct  = 0;
    hold_off_left   = HOLD_CYCLES;
    for (int i = 0; i < 30; i++) offer_command(random_goal_cmd());
    wait_all_results();
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall_pct);
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = KEY_W'($urandom);
    sender_idle_pct = idle_pct;
    sink_stall_pct  = stall_pct;
    offer_command(make_cmd(ACT_CLEAR, '0, '0, '0, '0, '0, '0));
    for (int i = 0; i < PHASE_WORDS; i++) offer_command(random_goal_cmd());
    wait_all_results();
  endtask

  // Receiver: random stalls, or a counted hold-off when one is requested
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_left != 0) begin
        rsp_ch.ready = 1'b0;
        hold_off_left--;
      end else begin
        rsp_ch.ready = (sink_stall_pct == 0) || ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  // Result checker: each accepted word against the oldest expectation
  always @(posedge clk) begin : result_check
    goal_rsp_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("word %0d arrived with nothing expected", words_checked));
      end else begin
        want = pending_results.pop_front();
        check_field("result_index", VAL_W'($unsigned(rsp_ch.result_index)),
                    VAL_W'($unsigned(want.result_index)));
        check_field("hit", VAL_W'(rsp_ch.hit), VAL_W'(want.hit));
        check_field("goal_count", VAL_W'(rsp_ch.goal_count), VAL_W'(want.goal_count));
        check_field("entry_key", VAL_W'(rsp_ch.entry_key), VAL_W'(want.entry_key));
        check_field("entry_flags", VAL_W'(rsp_ch.entry_flags), VAL_W'(want.entry_flags));
        check_field("entry_a", rsp_ch.entry_a, want.entry_a);
        check_field("entry_b", rsp_ch.entry_b, want.entry_b);
        check_field("entry_c", rsp_ch.entry_c, want.entry_c);
      end
      words_checked++;
    end
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) @(posedge clk) cycle_count++;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    cmd_ch.valid       = 1'b0;
    cmd_ch.action      = ACT_CLEAR;
    cmd_ch.key         = '0;
    cmd_ch.value_a     = '0;
    cmd_ch.value_b     = '0;
    cmd_ch.value_c     = '0;
    cmd_ch.flag_bits   = '0;
    cmd_ch.start_index = '0;
    tbl_count          = 0;
    mismatch_count     = 0;
    words_checked      = 0;
    sender_idle_pct    = 0;
    sink_stall_pct     = 0;
    hold_off_left      = 0;
    // Key pool must hold real keys before any random word is drawn
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = KEY_W'($urandom);

    // Reset asserted, then released on a falling edge
    rst = 1'b1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_empty_table();
    test_insert_merge();
    test_flags_and_scan();
    test_undefined_actions();
    test_table_full();
    test_backpressure();
    test_random_traffic(0, 0);
    test_random_traffic(51, 0);
    test_random_traffic(0, 51);
    test_random_traffic(30, 30);

    // Let any stray word surface before the verdict
    sink_stall_pct = 0;
    repeat (END_WAIT) @(negedge clk);
    if (mismatch_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
